@@ rtl/crfb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package crfb_pkg;

   localparam int CoordW = 12;
   localparam int EndW   = CoordW + 1;
   localparam int ProdW  = CoordW + 16;
   localparam int OffW   = CoordW + 2;
   localparam int QDepth = 2;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   localparam logic [15:0]     RstRowPitch = 16'd5120;
   localparam logic [CoordW-1:0] RstScreenW = CoordW'(12'd1280);
   localparam logic [CoordW-1:0] RstScreenH = CoordW'(12'd720);

   typedef enum logic [2:0] {
      REG_ENABLE       = 3'd0,
      REG_FB_BASE      = 3'd1,
      REG_ROW_PITCH    = 3'd2,
      REG_SCREEN_WIDTH = 3'd3,
      REG_SCREEN_HEIGHT = 3'd4,
      REG_PIXEL_FORMAT = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_DRAW  = 2'd0,
      MODE_FILL  = 2'd1,
      MODE_BLIT  = 2'd2,
      MODE_STEP  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      FMT_ARGB32 = 2'd0,
      FMT_RGB565 = 2'd1,
      FMT_BGR24  = 2'd2
   } fmt_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DISABLED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NO_RUN   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      KIND_REJECT = 3'd0,
      KIND_DRAW   = 3'd1,
      KIND_START  = 3'd2,
      KIND_CANCEL = 3'd3,
      KIND_STEP   = 3'd4
   } kind_type;

   typedef struct packed {
      logic              enable;
      logic [31:0]       fb_base;
      logic [15:0]       row_pitch;
      logic [CoordW-1:0] screen_width;
      logic [CoordW-1:0] screen_height;
      logic [1:0]        pixel_format;
   } cfg_type;

   typedef struct packed {
      kind_type          kind;
      status_type        status;
      logic              blit;
      logic [CoordW-1:0] col;
      logic [CoordW-1:0] row;
      logic [EndW-1:0]   col_end;
      logic [EndW-1:0]   row_end;
      logic [ProdW-1:0]  prod;
      logic [31:0]       color;
   } entry_type;

endpackage

`default_nettype wire

@@ rtl/crfb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crfb_front (
   input  crfb_pkg::cfg_type   cfg,
   input  logic [1:0]          mode,
   input  logic [15:0]         pos_x,
   input  logic [15:0]         pos_y,
   input  logic [15:0]         rect_w,
   input  logic [15:0]         rect_h,
   input  logic [31:0]         color,
   output crfb_pkg::entry_type entry
);
   import crfb_pkg::*;

   logic signed [16:0] x0;
   logic signed [16:0] y0;
   logic signed [16:0] x1;
   logic signed [16:0] y1;
   logic signed [16:0] x1c;
   logic signed [16:0] y1c;
   logic signed [16:0] sw_s;
   logic signed [16:0] sh_s;
   logic               draw_in;
   logic               start_empty;
   logic [CoordW-1:0]  mul_row;
   mode_type           md;

   always_comb begin
      md   = mode_type'(mode);
      sw_s = $signed(17'(cfg.screen_width));
      sh_s = $signed(17'(cfg.screen_height));
      x0   = pos_x[15] ? 17'sd0 : $signed({1'b0, pos_x});
      y0   = pos_y[15] ? 17'sd0 : $signed({1'b0, pos_y});
      x1   = $signed({pos_x[15], pos_x}) + $signed({rect_w[15], rect_w});
      y1   = $signed({pos_y[15], pos_y}) + $signed({rect_h[15], rect_h});
      x1c  = (x1 > sw_s) ? sw_s : x1;
      y1c  = (y1 > sh_s) ? sh_s : y1;
      start_empty = rect_w[15] || (rect_w == 16'd0) || rect_h[15] || (rect_h == 16'd0) ||
                    (x1c <= x0) || (y1c <= y0);
      draw_in = !pos_x[15] && !pos_y[15] &&
                (pos_x[14:0] < 15'(cfg.screen_width)) &&
                (pos_y[14:0] < 15'(cfg.screen_height));

      mul_row = (md == MODE_DRAW) ? pos_y[CoordW-1:0] : y0[CoordW-1:0];

      entry         = '0;
      entry.color   = color;
      entry.blit    = (md == MODE_BLIT);
      entry.col     = (md == MODE_DRAW) ? pos_x[CoordW-1:0] : x0[CoordW-1:0];
      entry.row     = y0[CoordW-1:0];
      entry.col_end = x1c[EndW-1:0];
      entry.row_end = y1c[EndW-1:0];
      entry.prod    = ProdW'(mul_row) * ProdW'(cfg.row_pitch);
      entry.status  = ST_OK;

      if (!cfg.enable) begin
         entry.kind   = KIND_REJECT;
         entry.status = ST_DISABLED;
      end else begin
         unique case (md)
            MODE_DRAW: begin
               entry.kind   = draw_in ? KIND_DRAW : KIND_REJECT;
               entry.status = draw_in ? ST_OK : ST_EMPTY;
            end
            MODE_FILL, MODE_BLIT: begin
               entry.kind = start_empty ? KIND_CANCEL : KIND_START;
            end
            MODE_STEP: begin
               entry.kind = KIND_STEP;
            end
            default: begin
               entry.kind = KIND_STEP;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ rtl/crfb_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crfb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  crfb_pkg::entry_type push_entry,
   input  logic                pop,
   output crfb_pkg::entry_type head,
   output logic                not_empty,
   output logic                full
);
   import crfb_pkg::*;

   entry_type        slot_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff;
   logic [QPtrW-1:0] wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff;
   logic [QPtrW-1:0] rd_ptr_in;
   logic [QCntW-1:0] count_ff;
   logic [QCntW-1:0] count_in;

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == QCntW'(QDepth));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCntW'(QDepth))
      else $error("queue count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == QCntW'($past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");

endmodule

`default_nettype wire

@@ rtl/crfb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crfb_back (
   input  logic                clock,
   input  logic                reset,
   input  crfb_pkg::cfg_type   cfg,
   input  crfb_pkg::entry_type entry,
   input  logic                entry_valid,
   output logic                entry_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_write_valid,
   output logic [31:0]         rsp_write_addr,
   output logic [31:0]         rsp_write_data,
   output logic [3:0]          rsp_byte_enable,
   output logic                rsp_last_pixel,
   output logic [1:0]          rsp_status
);
   import crfb_pkg::*;

   function automatic logic [OffW-1:0] col_offset(input logic [1:0] fmt,
                                                  input logic [CoordW-1:0] col);
      logic [OffW-1:0] c;
      c = OffW'(col);
      unique case (fmt_type'(fmt))
         FMT_ARGB32: col_offset = c << 2;
         FMT_RGB565: col_offset = c << 1;
         default:    col_offset = (c << 1) + c;
      endcase
   endfunction

   function automatic logic [31:0] pixel_data(input logic [1:0] fmt,
                                              input logic [31:0] c);
      unique case (fmt_type'(fmt))
         FMT_ARGB32: pixel_data = c;
         FMT_RGB565: pixel_data = {16'd0, c[23:19], c[15:10], c[7:3]};
         default:    pixel_data = {8'd0, c[23:0]};
      endcase
   endfunction

   function automatic logic [3:0] pixel_be(input logic [1:0] fmt);
      unique case (fmt_type'(fmt))
         FMT_ARGB32: pixel_be = 4'hF;
         FMT_RGB565: pixel_be = 4'h3;
         default:    pixel_be = 4'h7;
      endcase
   endfunction

   logic              run_active_ff, run_active_in;
   logic              run_is_blit_ff, run_is_blit_in;
   logic [CoordW-1:0] cursor_col_ff, cursor_col_in;
   logic [CoordW-1:0] cursor_row_ff, cursor_row_in;
   logic [CoordW-1:0] clip_left_ff, clip_left_in;
   logic [EndW-1:0]   clip_right_end_ff, clip_right_end_in;
   logic [EndW-1:0]   clip_bottom_end_ff, clip_bottom_end_in;
   logic [31:0]       held_color_ff, held_color_in;
   logic [31:0]       row_start_addr_ff, row_start_addr_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              write_valid_ff, write_valid_in;
   logic [31:0]       write_addr_ff, write_addr_in;
   logic [31:0]       write_data_ff, write_data_in;
   logic [3:0]        byte_enable_ff, byte_enable_in;
   logic              last_pixel_ff, last_pixel_in;
   status_type        status_ff, status_in;

   logic [EndW-1:0]   col_next;
   logic [EndW-1:0]   row_next;
   logic              row_done;
   logic              last_row;
   logic [CoordW-1:0] off_col;
   logic [OffW-1:0]   off;

   assign entry_pop = entry_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      col_next = EndW'(cursor_col_ff) + 1'b1;
      row_next = EndW'(cursor_row_ff) + 1'b1;
      row_done = (col_next >= clip_right_end_ff);
      last_row = (row_next >= clip_bottom_end_ff);
      off_col  = (entry.kind == KIND_STEP) ? cursor_col_ff : entry.col;
      off      = col_offset(cfg.pixel_format, off_col);

      run_active_in      = run_active_ff;
      run_is_blit_in     = run_is_blit_ff;
      cursor_col_in      = cursor_col_ff;
      cursor_row_in      = cursor_row_ff;
      clip_left_in       = clip_left_ff;
      clip_right_end_in  = clip_right_end_ff;
      clip_bottom_end_in = clip_bottom_end_ff;
      held_color_in      = held_color_ff;
      row_start_addr_in  = row_start_addr_ff;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      write_valid_in = write_valid_ff;
      write_addr_in  = write_addr_ff;
      write_data_in  = write_data_ff;
      byte_enable_in = byte_enable_ff;
      last_pixel_in  = last_pixel_ff;
      status_in      = status_ff;

      if (entry_pop) begin
         rsp_valid_in   = 1'b1;
         write_valid_in = 1'b0;
         write_addr_in  = '0;
         write_data_in  = '0;
         byte_enable_in = '0;
         last_pixel_in  = 1'b0;
         status_in      = ST_OK;
         unique case (entry.kind)
            KIND_REJECT: begin
               status_in = entry.status;
            end
            KIND_CANCEL: begin
               status_in     = ST_EMPTY;
               run_active_in = 1'b0;
            end
            KIND_START: begin
               run_active_in      = 1'b1;
               run_is_blit_in     = entry.blit;
               clip_left_in       = entry.col;
               clip_right_end_in  = entry.col_end;
               clip_bottom_end_in = entry.row_end;
               cursor_col_in      = entry.col;
               cursor_row_in      = entry.row;
               held_color_in      = entry.color;
               row_start_addr_in  = cfg.fb_base + 32'(entry.prod);
            end
            KIND_DRAW: begin
               write_valid_in = 1'b1;
               write_addr_in  = cfg.fb_base + 32'(entry.prod) + 32'(off);
               write_data_in  = pixel_data(cfg.pixel_format, entry.color);
               byte_enable_in = pixel_be(cfg.pixel_format);
            end
            KIND_STEP: begin
               if (!run_active_ff) begin
                  status_in = ST_NO_RUN;
               end else begin
                  write_valid_in = 1'b1;
                  write_addr_in  = row_start_addr_ff + 32'(off);
                  write_data_in  = pixel_data(cfg.pixel_format,
                                              run_is_blit_ff ? entry.color : held_color_ff);
                  byte_enable_in = pixel_be(cfg.pixel_format);
                  last_pixel_in  = row_done && last_row;
                  if (row_done) begin
                     if (last_row) begin
                        run_active_in = 1'b0;
                     end else begin
                        cursor_col_in     = clip_left_ff;
                        cursor_row_in     = row_next[CoordW-1:0];
                        row_start_addr_in = row_start_addr_ff + 32'(cfg.row_pitch);
                     end
                  end else begin
                     cursor_col_in = col_next[CoordW-1:0];
                  end
               end
            end
            default: begin
               status_in = entry.status;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         run_active_ff <= run_active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_is_blit_ff     <= run_is_blit_in;
      cursor_col_ff      <= cursor_col_in;
      cursor_row_ff      <= cursor_row_in;
      clip_left_ff       <= clip_left_in;
      clip_right_end_ff  <= clip_right_end_in;
      clip_bottom_end_ff <= clip_bottom_end_in;
      held_color_ff      <= held_color_in;
      row_start_addr_ff  <= row_start_addr_in;
      write_valid_ff     <= write_valid_in;
      write_addr_ff      <= write_addr_in;
      write_data_ff      <= write_data_in;
      byte_enable_ff     <= byte_enable_in;
      last_pixel_ff      <= last_pixel_in;
      status_ff          <= status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_write_valid = write_valid_ff;
   assign rsp_write_addr  = write_addr_ff;
   assign rsp_write_data  = write_data_ff;
   assign rsp_byte_enable = byte_enable_ff;
   assign rsp_last_pixel  = last_pixel_ff;
   assign rsp_status      = status_ff;

   a_cursor_inside: assert property (@(posedge clock) disable iff (reset)
      run_active_ff |-> (EndW'(cursor_col_ff) < clip_right_end_ff) &&
                        (EndW'(cursor_row_ff) < clip_bottom_end_ff))
      else $error("run cursor outside clip rectangle");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      entry_pop && (entry.kind == KIND_STEP) && run_active_ff && row_done && last_row
      |=> !run_active_ff && last_pixel_ff)
      else $error("final pixel did not close the run");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !write_valid_ff |-> (write_addr_ff == '0) && (write_data_ff == '0) &&
                                          (byte_enable_ff == '0) && !last_pixel_ff)
      else $error("write fields set on a result without a write");

endmodule

`default_nettype wire

@@ rtl/clipped_rect_fill_blit_engine_core.sv @@
// path: a taken req word is written into the queue, then into the back end's rsp registers
// throughput: one word per cycle while rsp_stall is low, set by the cursor update in the back end
// req_stall rises only when the two-entry queue is full behind a stalled rsp side
// reset: synchronous, active high; clears the queue, the run and the rsp valid
// configuration registers return to their documented reset values; no memory, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module clipped_rect_fill_blit_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_pos_x,
   input  logic [15:0] req_pos_y,
   input  logic [15:0] req_rect_w,
   input  logic [15:0] req_rect_h,
   input  logic [31:0] req_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_write_valid,
   output logic [31:0] rsp_write_addr,
   output logic [31:0] rsp_write_data,
   output logic [3:0]  rsp_byte_enable,
   output logic        rsp_last_pixel,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import crfb_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   entry_type front_entry;
   entry_type head_entry;
   logic      q_push;
   logic      q_pop;
   logic      q_not_empty;
   logic      q_full;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_ENABLE:        cfg_in.enable        = csr_wdata[0];
            REG_FB_BASE:       cfg_in.fb_base       = csr_wdata;
            REG_ROW_PITCH:     cfg_in.row_pitch     = csr_wdata[15:0];
            REG_SCREEN_WIDTH:  cfg_in.screen_width  = CoordW'(csr_wdata[11:0]);
            REG_SCREEN_HEIGHT: cfg_in.screen_height = CoordW'(csr_wdata[11:0]);
            REG_PIXEL_FORMAT:  cfg_in.pixel_format  = csr_wdata[1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable        <= 1'b0;
         cfg_ff.fb_base       <= '0;
         cfg_ff.row_pitch     <= RstRowPitch;
         cfg_ff.screen_width  <= RstScreenW;
         cfg_ff.screen_height <= RstScreenH;
         cfg_ff.pixel_format  <= FMT_ARGB32;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   crfb_front u_front (
      .cfg    (cfg_ff),
      .mode   (req_mode),
      .pos_x  (req_pos_x),
      .pos_y  (req_pos_y),
      .rect_w (req_rect_w),
      .rect_h (req_rect_h),
      .color  (req_color),
      .entry  (front_entry)
   );

   crfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (front_entry),
      .pop        (q_pop),
      .head       (head_entry),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   crfb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .entry           (head_entry),
      .entry_valid     (q_not_empty),
      .entry_pop       (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_write_valid (rsp_write_valid),
      .rsp_write_addr  (rsp_write_addr),
      .rsp_write_data  (rsp_write_data),
      .rsp_byte_enable (rsp_byte_enable),
      .rsp_last_pixel  (rsp_last_pixel),
      .rsp_status      (rsp_status)
   );

endmodule

`default_nettype wire

@@ verif/clipped_rect_fill_blit_engine_core_tb.sv @@
`timescale 1ns / 1ps

module clipped_rect_fill_blit_engine_core_tb;
   import crfb_pkg::*;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] rect_w;
      logic [15:0] rect_h;
      logic [31:0] color;
   } draw_cmd_t;

   typedef struct packed {
      logic        write_valid;
      logic [31:0] addr;
      logic [31:0] data;
      logic [3:0]  be;
      logic        last_px;
      status_type  status;
   } pix_wr_t;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_write_valid;
   logic [31:0] rsp_write_addr;
   logic [31:0] rsp_write_data;
   logic [3:0]  rsp_byte_enable;
   logic        rsp_last_pixel;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   draw_cmd_t drv_cmd = '0;
   logic      req_fire = 1'b0;

   draw_cmd_t cmd_queue[$];
   pix_wr_t   expected_writes[$];

   int mismatches = 0;
   int queued_cmds = 0;
   int accepted_cmds = 0;
   int checked_results = 0;
   int pixel_writes = 0;
   int reg_writes = 0;

   int gap_left = 0;
   int burst_left = 0;
   bit tx_steady = 1'b0;

   int hold_asked = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int pat_left = 0;
   int pat_tick = 0;
   int stall_style = 0;

   // shadow of the block
   cfg_type     live_cfg = '{enable: 1'b0, fb_base: 32'd0, row_pitch: RstRowPitch,
                             screen_width: RstScreenW, screen_height: RstScreenH,
                             pixel_format: 2'd0};
   logic        run_on = 1'b0;
   logic        run_blit = 1'b0;
   logic [11:0] cur_col = '0;
   logic [11:0] cur_row = '0;
   logic [11:0] left_col = '0;
   logic [12:0] right_end = '0;
   logic [12:0] bottom_end = '0;
   logic [31:0] fill_color = '0;
   logic [31:0] row_base = '0;

   logic [1:0]  req_mode;
   logic [15:0] req_pos_x;
   logic [15:0] req_pos_y;
   logic [15:0] req_rect_w;
   logic [15:0] req_rect_h;
   logic [31:0] req_color;

   assign req_mode   = drv_cmd.mode;
   assign req_pos_x  = drv_cmd.pos_x;
   assign req_pos_y  = drv_cmd.pos_y;
   assign req_rect_w = drv_cmd.rect_w;
   assign req_rect_h = drv_cmd.rect_h;
   assign req_color  = drv_cmd.color;

   clipped_rect_fill_blit_engine_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_rect_w      (req_rect_w),
      .req_rect_h      (req_rect_h),
      .req_color       (req_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_write_valid (rsp_write_valid),
      .rsp_write_addr  (rsp_write_addr),
      .rsp_write_data  (rsp_write_data),
      .rsp_byte_enable (rsp_byte_enable),
      .rsp_last_pixel  (rsp_last_pixel),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] bytes_per_px();
      case (live_cfg.pixel_format)
         FMT_ARGB32: return 32'd4;
         FMT_RGB565: return 32'd2;
         default:    return 32'd3;
      endcase
   endfunction

   function automatic void pack_pixel(input logic [31:0] c, output logic [31:0] d,
                                      output logic [3:0] be);
      case (live_cfg.pixel_format)
         FMT_ARGB32: begin
            d  = c;
            be = 4'd15;
         end
         FMT_RGB565: begin
            d  = {16'd0, c[23:19], c[15:10], c[7:3]};
            be = 4'd3;
         end
         default: begin
            d  = {8'd0, c[23:0]};
            be = 4'd7;
         end
      endcase
   endfunction

   function automatic pix_wr_t render_command(input draw_cmd_t c);
      pix_wr_t     r;
      int          px, py, rw, rh, x0, y0, x1, y1;
      logic [31:0] d;
      logic [3:0]  be;
      logic        col_done, row_done;
      r  = '0;
      px = $signed(c.pos_x);
      py = $signed(c.pos_y);
      rw = $signed(c.rect_w);
      rh = $signed(c.rect_h);
      if (!live_cfg.enable) begin
         r.status = ST_DISABLED;
         return r;
      end
      case (c.mode)
         MODE_DRAW: begin
            if (px < 0 || py < 0 || px >= int'(live_cfg.screen_width) ||
                py >= int'(live_cfg.screen_height)) begin
               r.status = ST_EMPTY;
            end else begin
               pack_pixel(c.color, d, be);
               r.write_valid = 1'b1;
               r.addr = live_cfg.fb_base + 32'(py) * 32'(live_cfg.row_pitch) +
                        32'(px) * bytes_per_px();
               r.data = d;
               r.be   = be;
            end
         end
         MODE_FILL, MODE_BLIT: begin
            x0 = px;
            y0 = py;
            x1 = px + rw;
            y1 = py + rh;
            if (x0 < 0) x0 = 0;
            if (y0 < 0) y0 = 0;
            if (x1 > int'(live_cfg.screen_width)) x1 = int'(live_cfg.screen_width);
            if (y1 > int'(live_cfg.screen_height)) y1 = int'(live_cfg.screen_height);
            if (rw <= 0 || rh <= 0 || x1 - x0 <= 0 || y1 - y0 <= 0) begin
               run_on   = 1'b0;
               r.status = ST_EMPTY;
            end else begin
               run_on     = 1'b1;
               run_blit   = (c.mode == MODE_BLIT);
               left_col   = 12'(x0);
               right_end  = 13'(x1);
               bottom_end = 13'(y1);
               cur_col    = left_col;
               cur_row    = 12'(y0);
               fill_color = c.color;
               row_base   = live_cfg.fb_base + 32'(cur_row) * 32'(live_cfg.row_pitch);
            end
         end
         default: begin
            if (!run_on) begin
               r.status = ST_NO_RUN;
            end else begin
               col_done = (32'(cur_col) + 32'd1 >= 32'(right_end));
               row_done = (32'(cur_row) + 32'd1 >= 32'(bottom_end));
               pack_pixel(run_blit ? c.color : fill_color, d, be);
               r.write_valid = 1'b1;
               r.addr    = row_base + 32'(cur_col) * bytes_per_px();
               r.data    = d;
               r.be      = be;
               r.last_px = col_done && row_done;
               if (col_done) begin
                  if (row_done) begin
                     run_on = 1'b0;
                  end else begin
                     cur_col  = left_col;
                     cur_row  = cur_row + 12'd1;
                     row_base = row_base + 32'(live_cfg.row_pitch);
                  end
               end else begin
                  cur_col = cur_col + 12'd1;
               end
            end
         end
      endcase
      return r;
   endfunction

   function automatic logic [15:0] rand16();
      return 16'($urandom());
   endfunction

   task automatic push_cmd(input mode_type m, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] w, input logic [15:0] h,
                           input logic [31:0] c);
      cmd_queue.push_back('{mode: m, pos_x: x, pos_y: y, rect_w: w, rect_h: h, color: c});
      queued_cmds++;
   endtask

   task automatic flag_error(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic settle();
      @(posedge clock);
      while (cmd_queue.size() != 0 || req_valid || expected_writes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_ENABLE:        live_cfg.enable = val[0];
         REG_FB_BASE:       live_cfg.fb_base = val;
         REG_ROW_PITCH:     live_cfg.row_pitch = val[15:0];
         REG_SCREEN_WIDTH:  live_cfg.screen_width = val[11:0];
         REG_SCREEN_HEIGHT: live_cfg.screen_height = val[11:0];
         default:           live_cfg.pixel_format = val[1:0];
      endcase
      reg_writes++;
   endtask

   task automatic apply_setting(input cfg_type s);
      settle();
      tx_steady = 1'b0;
      csr_write(REG_ENABLE, 32'(s.enable));
      csr_write(REG_FB_BASE, s.fb_base);
      csr_write(REG_ROW_PITCH, 32'(s.row_pitch));
      csr_write(REG_SCREEN_WIDTH, 32'(s.screen_width));
      csr_write(REG_SCREEN_HEIGHT, 32'(s.screen_height));
      csr_write(REG_PIXEL_FORMAT, 32'(s.pixel_format));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // driver: bursts with random gaps
   always @(negedge clock) begin
      draw_cmd_t nxt;
      logic      send;
      nxt  = drv_cmd;
      send = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_fire)) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
         end else if (cmd_queue.size() != 0) begin
            nxt  = cmd_queue.pop_front();
            send = 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               if (tx_steady || $urandom_range(0, 3) == 0) gap_left <= 0;
               else gap_left <= $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
         req_valid <= send;
         if (send) drv_cmd <= nxt;
      end
   end

   // receiver stall pattern, with an occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= 240;
         rsp_stall <= 1'b1;
      end else begin
         if (pat_left == 0) begin
            pat_left    <= $urandom_range(8, 80);
            stall_style <= $urandom_range(0, 3);
         end else begin
            pat_left <= pat_left - 1;
         end
         pat_tick <= pat_tick + 1;
         case (stall_style)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (pat_tick % 3 == 0);
         endcase
      end
   end

   // monitor: check each rsp word against the oldest prediction
   always @(posedge clock) begin
      pix_wr_t got, want;
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.write_valid = rsp_write_valid;
            got.addr        = rsp_write_addr;
            got.data        = rsp_write_data;
            got.be          = rsp_byte_enable;
            got.last_px     = rsp_last_pixel;
            got.status      = status_type'(rsp_status);
            if (rsp_write_valid) pixel_writes++;
            if (expected_writes.size() == 0) begin
               flag_error($sformatf("unexpected word wv=%0b addr=%h data=%h be=%h last=%0b st=%0d",
                  got.write_valid, got.addr, got.data, got.be, got.last_px, got.status));
            end else begin
               want = expected_writes.pop_front();
               checked_results++;
               if (got.write_valid !== want.write_valid || got.addr !== want.addr ||
                   got.data !== want.data || got.be !== want.be ||
                   got.last_px !== want.last_px || got.status !== want.status) begin
                  flag_error($sformatf(
                     "exp wv=%0b addr=%h data=%h be=%h last=%0b st=%0d / got wv=%0b addr=%h data=%h be=%h last=%0b st=%0d",
                     want.write_valid, want.addr, want.data, want.be, want.last_px, want.status,
                     got.write_valid, got.addr, got.data, got.be, got.last_px, got.status));
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_writes.push_back(render_command(drv_cmd));
            accepted_cmds++;
         end
      end
   end

   initial begin
      #4_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      cfg_type s;
      int      x, y, w, h, k, pick, start_cnt;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // disabled after reset
      push_cmd(MODE_DRAW, 16'd5, 16'd5, 16'd0, 16'd0, 32'h12345678);
      push_cmd(MODE_FILL, 16'd0, 16'd0, 16'd2, 16'd2, 32'h0);

      s = '{enable: 1'b1, fb_base: 32'h1000_0000, row_pitch: 16'd5120,
            screen_width: 12'd1280, screen_height: 12'd720, pixel_format: FMT_ARGB32};
      apply_setting(s);
      push_cmd(MODE_DRAW, 16'd0, 16'd0, 16'd0, 16'd0, 32'h12345678);
      push_cmd(MODE_DRAW, 16'd1279, 16'd719, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
      push_cmd(MODE_DRAW, 16'hFFFF, 16'd0, 16'd0, 16'd0, 32'h1);
      push_cmd(MODE_DRAW, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 32'h2);
      push_cmd(MODE_FILL, 16'd0, 16'd0, 16'd0, 16'd5, 32'h3);
      push_cmd(MODE_FILL, 16'd0, 16'd0, 16'd5, 16'h8000, 32'h4);
      push_cmd(MODE_FILL, 16'hFFFE, 16'hFFFE, 16'd4, 16'd3, 32'hCAFEF00D);
      push_cmd(MODE_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0);
      push_cmd(MODE_STEP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
      push_cmd(MODE_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0);
      push_cmd(MODE_BLIT, 16'd1278, 16'd718, 16'h7FFF, 16'h7FFF, 32'h0);
      push_cmd(MODE_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h00000000);
      push_cmd(MODE_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'hFFFFFFFF);
      push_cmd(MODE_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'hAAAAAAAA);
      push_cmd(MODE_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h55555555);
      push_cmd(MODE_FILL, 16'd10, 16'd10, 16'd3, 16'd3, 32'h00FF00FF);
      push_cmd(MODE_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0);
      push_cmd(MODE_BLIT, 16'd0, 16'd0, 16'd1, 16'd1, 32'h0);
      push_cmd(MODE_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h87654321);
      push_cmd(MODE_FILL, 16'd5, 16'd5, 16'd2, 16'd2, 32'h11111111);
      push_cmd(MODE_FILL, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 32'h0);
      push_cmd(MODE_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0);
      // run left open across the next register change
      push_cmd(MODE_FILL, 16'd1278, 16'd0, 16'd4, 16'd2, 32'h00F8FC18);
      push_cmd(MODE_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0);

      s = '{enable: 1'b1, fb_base: 32'hFFFF_FFF0, row_pitch: 16'hFFFF,
            screen_width: 12'd1280, screen_height: 12'd720, pixel_format: 2'd3};
      apply_setting(s);
      repeat (3) push_cmd(MODE_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0);

      s.pixel_format = FMT_RGB565;
      apply_setting(s);
      push_cmd(MODE_DRAW, 16'd3, 16'd3, 16'd0, 16'd0, 32'hFFFFFFFF);
      push_cmd(MODE_DRAW, 16'd3, 16'd4, 16'd0, 16'd0, 32'h00F8FC18);

      // zero screen sizes clip everything
      s = '{enable: 1'b1, fb_base: 32'h0, row_pitch: 16'd1, screen_width: 12'd0,
            screen_height: 12'd5, pixel_format: FMT_BGR24};
      apply_setting(s);
      push_cmd(MODE_DRAW, 16'd0, 16'd0, 16'd0, 16'd0, 32'h1);
      push_cmd(MODE_FILL, 16'd0, 16'd0, 16'd1, 16'd1, 32'h1);
      push_cmd(MODE_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h1);
      s.screen_width  = 12'd5;
      s.screen_height = 12'd0;
      apply_setting(s);
      push_cmd(MODE_BLIT, 16'd0, 16'd0, 16'd1, 16'd1, 32'h1);

      // long receiver hold-off while the sender keeps offering
      s = '{enable: 1'b1, fb_base: 32'hFFFF_FFFF, row_pitch: 16'hFFFF,
            screen_width: 12'd4095, screen_height: 12'd4095, pixel_format: FMT_BGR24};
      apply_setting(s);
      tx_steady = 1'b1;
      for (k = 0; k < 60; k++)
         push_cmd(MODE_DRAW, 16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)),
                  rand16(), rand16(), $urandom());
      hold_asked++;

      for (int ph = 0; ph < 10; ph++) begin
         s.enable = ($urandom_range(0, 9) != 0);
         pick = $urandom_range(0, 3);
         s.fb_base = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();
         pick = $urandom_range(0, 3);
         s.row_pitch = (pick == 0) ? 16'd1 : (pick == 1) ? 16'hFFFF :
                       16'($urandom_range(1, 65535));
         pick = $urandom_range(0, 3);
         s.screen_width = (pick == 0) ? 12'd1 : (pick == 1) ? 12'd4095 :
                          (pick == 2) ? 12'($urandom_range(1, 64)) :
                          12'($urandom_range(1, 4095));
         pick = $urandom_range(0, 3);
         s.screen_height = (pick == 0) ? 12'd1 : (pick == 1) ? 12'd4095 :
                           (pick == 2) ? 12'($urandom_range(1, 64)) :
                           12'($urandom_range(1, 4095));
         s.pixel_format = 2'($urandom_range(0, 3));
         apply_setting(s);
         start_cnt = queued_cmds;
         while (queued_cmds - start_cnt < 200) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
               x = int'($urandom_range(0, int'(s.screen_width) + 1)) - 2;
               y = int'($urandom_range(0, int'(s.screen_height) + 1)) - 2;
               w = $urandom_range(1, 6);
               h = $urandom_range(1, 4);
               push_cmd($urandom_range(0, 1) ? MODE_FILL : MODE_BLIT, 16'(x), 16'(y),
                        16'(w), 16'(h), $urandom());
               k = w * h;
               if ($urandom_range(0, 7) == 0) k = k + int'($urandom_range(0, 2)) - 1;
               repeat (k)
                  push_cmd(MODE_STEP, rand16(), rand16(), rand16(), rand16(), $urandom());
            end else if (pick <= 7) begin
               x = int'($urandom_range(0, int'(s.screen_width) + 1)) - 1;
               y = int'($urandom_range(0, int'(s.screen_height) + 1)) - 1;
               push_cmd(MODE_DRAW, 16'(x), 16'(y), rand16(), rand16(), $urandom());
            end else if (pick == 8) begin
               push_cmd(mode_type'($urandom_range(0, 3)), rand16(), rand16(), rand16(),
                        rand16(), $urandom());
            end else begin
               push_cmd(MODE_STEP, rand16(), rand16(), rand16(), rand16(), $urandom());
            end
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (expected_writes.size() != 0)
         flag_error($sformatf("%0d predicted words never arrived", expected_writes.size()));
      $display("%0d commands over draw, fill, blit and step, %0d words checked",
               accepted_cmds, checked_results);
      $display("%0d pixel writes, %0d register writes, %0d mismatches",
               pixel_writes, reg_writes, mismatches);
      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
